### hdl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg - shared types and constants for the ordered list core
// Holds list depth, command/status codes, payload structs and cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } olst_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     last;
  } olst_out_t;

  typedef enum logic [1:0] {
    OLST_IDLE,
    OLST_MATCH,
    OLST_DUMP
  } olst_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_CMP,
    CELL_SHIFT,
    CELL_DEL,
    CELL_ROT
  } olst_cell_op_t;

  typedef struct packed {
    olst_cell_op_t     op;
    logic [OCC_W-1:0]  occ;
    logic [DATA_W-1:0] key;
  } olst_cell_ctl_t;

endpackage

`default_nettype wire

### hdl/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell - one slot of the ordered list
// Stores one entry, compares it to a key and takes its neighbor's entry when
// the list shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_cell (
  input  wire logic                          clk,
  input  wire olst_pkg::olst_cell_ctl_t      ctl,
  input  wire logic [olst_pkg::IDX_W-1:0]    idx,
  input  wire logic [olst_pkg::DATA_W-1:0]   next_val,
  input  wire logic [olst_pkg::DATA_W-1:0]   head_val,
  input  wire logic                          hit_in,
  output logic [olst_pkg::DATA_W-1:0]        val,
  output logic                               hit_out
);
  import olst_pkg::*;

  logic [DATA_W-1:0] val_r, val_nxt;
  logic              match_r, match_nxt;
  logic [OCC_W-1:0]  slot;
  logic              in_use;

  assign slot   = OCC_W'(idx);
  assign in_use = slot < ctl.occ;

  // hit_out marks this slot or an earlier one as holding the first match
  assign hit_out = hit_in | match_r;
  assign val     = val_r;

  always_comb begin
    val_nxt   = val_r;
    match_nxt = match_r;
    case (ctl.op)
      CELL_APPEND: if (slot == ctl.occ) val_nxt = ctl.key;
      CELL_CMP:    match_nxt = in_use && (val_r == ctl.key);
      CELL_SHIFT:  val_nxt = next_val;
      CELL_DEL:    if (hit_out) val_nxt = next_val;
      CELL_ROT:    val_nxt = (slot == ctl.occ - OCC_W'(1)) ? head_val : next_val;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

endmodule

`default_nettype wire

### hdl/ordered_list_delete_by_value_core.sv
// ----------------------------------------------------------------------------
// ordered_list_delete_by_value_core - ordered list with delete by value
// Row of list cells plus the command sequencer and a registered result port.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command item (append, remove first
//   match, pop head, dump). out_valid/out_ready/out_data return result items;
//   every command gives one result with last set, except a dump of a non-empty
//   list, which gives one result per entry, head first, last on the tail.
// Latency / throughput:
//   Append and pop: result registered in the cycle after accept; a new item can
//   be accepted every cycle while the receiver takes results.
//   Remove: compare in every cell, then ripple of the first-match flag down the
//   row and gap close. Dump: results leave head first; the row rotates one slot
//   per result, set by the single head read port.
// Reset: rst_n clears occupancy, the sequencer and the result valid flag; the
//   stored entries are not cleared and are never read before written.
// Stall: a held result freezes the sequencer; in_ready stays low until the
//   result register can take the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_delete_by_value_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire olst_pkg::olst_in_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output olst_pkg::olst_out_t        out_data
);
  import olst_pkg::*;

  olst_state_t      state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] dcnt_r, dcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  olst_out_t        out_r, out_nxt;

  olst_cell_ctl_t    ctl;
  logic [DATA_W-1:0] vals [DEPTH];
  logic              hits [DEPTH];
  logic              accept, out_free, found, dump_last, out_load;

  assign out_free  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign found     = hits[DEPTH-1];
  assign dump_last = OCC_W'(dcnt_r) == (occ_r - OCC_W'(1));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // row of cells, each feeding its entry to the slot before it
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] nv;
    logic              hi;
    if (g == DEPTH - 1) begin : g_tail
      assign nv = '0;
    end else begin : g_mid
      assign nv = vals[g+1];
    end
    if (g == 0) begin : g_head
      assign hi = 1'b0;
    end else begin : g_rest
      assign hi = hits[g-1];
    end
    olst_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(g)),
      .next_val (nv),
      .head_val (vals[0]),
      .hit_in   (hi),
      .val      (vals[g]),
      .hit_out  (hits[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      OLST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_REMOVE) state_nxt = OLST_MATCH;
          else if (in_data.command == CMD_DUMP && occ_r != '0) state_nxt = OLST_DUMP;
        end
      end
      OLST_MATCH: state_nxt = OLST_IDLE;
      OLST_DUMP:  if (out_free && dump_last) state_nxt = OLST_IDLE;
      default:    state_nxt = OLST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl.op   = CELL_HOLD;
    ctl.occ  = occ_r;
    ctl.key  = in_data.value;
    occ_nxt  = occ_r;
    dcnt_nxt = dcnt_r;
    out_load = 1'b0;
    out_nxt  = out_r;
    unique case (state_r)
      OLST_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          out_nxt.data   = '0;
          out_nxt.status = ST_OK;
          out_nxt.last   = 1'b1;
          dcnt_nxt       = '0;
          case (in_data.command)
            CMD_APPEND: begin
              out_load = 1'b1;
              if (occ_r == OCC_W'(DEPTH)) begin
                out_nxt.status = ST_FULL;
              end else begin
                ctl.op  = CELL_APPEND;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            CMD_REMOVE: ctl.op = CELL_CMP;
            CMD_POP: begin
              out_load = 1'b1;
              if (occ_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_nxt.data = vals[0];
                ctl.op       = CELL_SHIFT;
                occ_nxt      = occ_r - OCC_W'(1);
              end
            end
            default: begin
              if (occ_r == '0) begin
                out_load       = 1'b1;
                out_nxt.status = ST_EMPTY;
              end
            end
          endcase
        end
      end
      OLST_MATCH: begin
        // result register is free here: it was free when the item was taken
        out_load       = 1'b1;
        out_nxt.data   = '0;
        out_nxt.last   = 1'b1;
        out_nxt.status = found ? ST_OK : ST_NOTFOUND;
        if (found) begin
          ctl.op  = CELL_DEL;
          occ_nxt = occ_r - OCC_W'(1);
        end
      end
      OLST_DUMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_nxt.data   = vals[0];
          out_nxt.status = ST_OK;
          out_nxt.last   = dump_last;
          ctl.op         = CELL_ROT;
          dcnt_nxt       = dcnt_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= OLST_IDLE;
      occ_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - ordered list core with delete by value
// Drives append/remove/pop/dump items with random idling on both channels,
// predicts every result with a list model and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olst_pkg::*;

  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;

  localparam int BURST_FILL  = 0;
  localparam int BURST_DRAIN = 1;
  localparam int BURST_MIXED = 2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  olst_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  olst_out_t out_data;

  ordered_list_delete_by_value_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // list model and results still owed by the core
  logic signed [DATA_W-1:0] list_model[$];
  olst_out_t                expected_results[$];
  olst_in_t                 pending_items[$];
  logic signed [DATA_W-1:0] value_pool[12];

  int items_total    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;

  int unsigned tx_gap    = 0;
  int unsigned rx_gap    = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        rx_hold;

  assign rx_hold = (hold_left != 0);

  // mostly short gaps, a few long ones; none at all while steady
  function automatic int unsigned gap_len(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_command(input int kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      BURST_FILL: begin
        if (r < 75) return CMD_APPEND;
        if (r < 85) return CMD_REMOVE;
        if (r < 93) return CMD_POP;
      end
      BURST_DRAIN: begin
        if (r < 15) return CMD_APPEND;
        if (r < 55) return CMD_REMOVE;
        if (r < 90) return CMD_POP;
      end
      default: begin
        if (r < 40) return CMD_APPEND;
        if (r < 65) return CMD_REMOVE;
        if (r < 88) return CMD_POP;
      end
    endcase
    return CMD_DUMP;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
    olst_in_t it;
    it.command = cmd;
    it.value   = val;
    pending_items.push_back(it);
    items_total++;
  endtask

  // applies one accepted command to the list model, queues its results
  task automatic apply_command(input olst_in_t item);
    olst_out_t r;
    int        hit;
    hit      = -1;
    r        = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (item.command)
      CMD_APPEND: begin
        if (list_model.size() >= DEPTH) r.status = ST_FULL;
        else list_model.push_back(item.value);
        expected_results.push_back(r);
      end
      CMD_REMOVE: begin
        for (int i = 0; i < list_model.size(); i++)
          if (hit < 0 && list_model[i] == item.value) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else list_model.delete(hit);
        expected_results.push_back(r);
      end
      CMD_POP: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else r.data = list_model.pop_front();
        expected_results.push_back(r);
      end
      CMD_DUMP: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            r.data = list_model[i];
            r.last = (i == list_model.size() - 1);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_command(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) tx_steady = ~tx_steady;
          tx_gap   <= gap_len(tx_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    olst_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: data %0d status %0d last %0d",
                 out_data.data, out_data.status, out_data.last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, out_data.data);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            error_count++;
          end
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        out_ready <= 1'b0;
        rx_gap    <= rx_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) begin
          if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
          rx_gap <= gap_len(rx_steady);
        end
      end
    end
  end

  // one long receiver hold-off so the core fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int burst;
    int random_items;

    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = 32'sd1;
    value_pool[3] = 32'sh7FFF_FFFF;
    value_pool[4] = 32'sh8000_0000;
    for (int i = 5; i < 12; i++) value_pool[i] = $urandom;

    // directed: empty-list corners, extremes, duplicates, first-match remove
    add_item(CMD_POP, $urandom);
    add_item(CMD_REMOVE, 32'sd0);
    add_item(CMD_DUMP, $urandom);
    add_item(CMD_APPEND, 32'sh7FFF_FFFF);
    add_item(CMD_APPEND, 32'sh8000_0000);
    add_item(CMD_APPEND, 32'sd0);
    add_item(CMD_APPEND, -32'sd1);
    add_item(CMD_APPEND, 32'sd7);
    add_item(CMD_APPEND, 32'sd42);
    add_item(CMD_APPEND, 32'sd7);
    add_item(CMD_DUMP, $urandom);
    add_item(CMD_REMOVE, 32'sd7);
    add_item(CMD_REMOVE, 32'sd123456);
    add_item(CMD_REMOVE, -32'sd1);
    add_item(CMD_DUMP, $urandom);
    add_item(CMD_POP, $urandom);
    add_item(CMD_POP, $urandom);
    add_item(CMD_REMOVE, 32'sd42);
    add_item(CMD_DUMP, $urandom);
    add_item(CMD_POP, $urandom);
    add_item(CMD_POP, $urandom);
    add_item(CMD_POP, $urandom);
    add_item(CMD_APPEND, -32'sd1);
    add_item(CMD_REMOVE, -32'sd1);
    add_item(CMD_DUMP, $urandom);

    // fill past capacity so append hits full, then dump the full list
    random_items = 0;
    for (int i = 0; i < DEPTH + 2; i++) begin
      add_item(CMD_APPEND, pick_value());
      random_items++;
    end
    add_item(CMD_DUMP, $urandom);
    random_items++;

    while (random_items < RANDOM_ITEMS) begin
      kind  = $urandom_range(BURST_FILL, BURST_MIXED);
      burst = $urandom_range(20, 45);
      for (int i = 0; i < burst && random_items < RANDOM_ITEMS; i++) begin
        add_item(pick_command(kind), pick_value());
        random_items++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != items_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ordered_list_delete_by_value_core] OK");
    end else begin
      $display("[ordered_list_delete_by_value_core] ERROR");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("[ordered_list_delete_by_value_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/olst_pkg.sv
hdl/olst_cell.sv
hdl/ordered_list_delete_by_value_core.sv
sim/testbench.sv
